// File: design/mbsp_pkg.sv
package mbsp_pkg;

   localparam int unsigned SYSEX_MAX_DEF = 256;

   // Result field widths.
   localparam int unsigned KIND_W = 3;
   localparam int unsigned CHAN_W = 4;
   localparam int unsigned DATA_W = 8;
   localparam int unsigned BEND_W = 16;
   localparam int unsigned LEN_W  = 9;

   // Result queue sizing: one byte can produce two results.
   localparam int unsigned MAX_PUSH = 2;
   localparam int unsigned Q_DEPTH  = 4;
   localparam int unsigned PTR_W    = $clog2(Q_DEPTH);
   localparam int unsigned FILL_W   = PTR_W + 1;

   // Upper nibble of a status byte.
   localparam logic [3:0] ST_NOTE_OFF = 4'h8;
   localparam logic [3:0] ST_NOTE_ON  = 4'h9;
   localparam logic [3:0] ST_CC       = 4'hB;
   localparam logic [3:0] ST_PROGRAM  = 4'hC;
   localparam logic [3:0] ST_BEND     = 4'hE;
   localparam logic [3:0] ST_SYSTEM   = 4'hF;

   // Lower nibble of a system status byte.
   localparam logic [3:0] SYS_SYSEX_START = 4'h0;
   localparam logic [3:0] SYS_SONG_POS    = 4'h2;
   localparam logic [3:0] SYS_RESET       = 4'hF;

   localparam logic [DATA_W-1:0] SYSEX_END_BYTE = 8'hF7;

   typedef enum logic [KIND_W-1:0] {
      EV_NOTE_ON    = 3'd0,
      EV_NOTE_OFF   = 3'd1,
      EV_CC         = 3'd2,
      EV_BEND       = 3'd3,
      EV_PROGRAM    = 3'd4,
      EV_SYSEX_BYTE = 3'd5,
      EV_SYSEX_END  = 3'd6,
      EV_RESET      = 3'd7
   } event_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FIRST,
      PH_SECOND,
      PH_SYSEX
   } phase_type;

   typedef struct packed {
      event_kind_type    event_kind;
      logic [CHAN_W-1:0] channel;
      logic [DATA_W-1:0] data_first;
      logic [DATA_W-1:0] data_second;
      logic [BEND_W-1:0] bend_value;
      logic [LEN_W-1:0]  sysex_length;
      logic              last;
   } rsp_type;

   // Results written into the queue together in the same cycle, first before second.
   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

// File: design/mbsp_req_if.sv
interface mbsp_req_if import mbsp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// File: design/mbsp_rsp_if.sv
interface mbsp_rsp_if import mbsp_pkg::*; ();
   logic              valid;
   logic              ready;
   event_kind_type    event_kind;
   logic [CHAN_W-1:0] channel;
   logic [DATA_W-1:0] data_first;
   logic [DATA_W-1:0] data_second;
   logic [BEND_W-1:0] bend_value;
   logic [LEN_W-1:0]  sysex_length;
   logic              last;

   modport source (output valid, output event_kind, output channel, output data_first,
                   output data_second, output bend_value, output sysex_length,
                   output last, input ready);
   modport sink (input valid, input event_kind, input channel, input data_first,
                 input data_second, input bend_value, input sysex_length,
                 input last, output ready);
endinterface

// File: design/mbsp_parser.sv
module mbsp_parser import mbsp_pkg::*; #(
   parameter int unsigned SYSEX_MAX = SYSEX_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DATA_W-1:0] in_byte,
   output logic              in_ready,
   input  logic              room,
   output push_type          push
);

   localparam int unsigned CNT_W = $clog2(SYSEX_MAX + 1);

   logic              byte_vld_ff, byte_vld_in;
   logic [DATA_W-1:0] byte_ff;
   phase_type         phase_ff, phase_in;
   logic [DATA_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0] first_ff, first_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  cnt_inc;
   logic              advance;
   logic              in_fire;

   // The held byte is decoded once the queue has room for two results.
   assign advance  = byte_vld_ff && room;
   assign in_ready = !byte_vld_ff || room;
   assign in_fire  = in_valid && in_ready;
   assign cnt_inc  = count_ff + CNT_W'(1);

   always_comb begin
      if (in_fire) begin
         byte_vld_in = 1'b1;
      end else if (advance) begin
         byte_vld_in = 1'b0;
      end else begin
         byte_vld_in = byte_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         status_ff   <= '0;
         first_ff    <= '0;
         count_ff    <= '0;
      end else begin
         byte_vld_ff <= byte_vld_in;
         phase_ff    <= phase_in;
         status_ff   <= status_in;
         first_ff    <= first_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         byte_ff <= in_byte;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      status_in = status_ff;
      first_in  = first_ff;
      count_in  = count_ff;
      push      = '0;
      if (advance) begin
         unique case (phase_ff)
            PH_IDLE: begin
               status_in = byte_ff;
               unique case (byte_ff[7:4]) inside
                  ST_NOTE_ON, ST_NOTE_OFF, ST_CC, ST_PROGRAM, ST_BEND: begin
                     phase_in = PH_FIRST;
                  end
                  ST_SYSTEM: begin
                     case (byte_ff[3:0])
                        SYS_SONG_POS: phase_in = PH_FIRST;
                        SYS_SYSEX_START: begin
                           count_in = '0;
                           phase_in = PH_SYSEX;
                        end
                        SYS_RESET: begin
                           push.num              = 2'd1;
                           push.first.event_kind = EV_RESET;
                           push.first.last       = 1'b1;
                        end
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
            PH_FIRST: begin
               first_in = byte_ff;
               if (status_ff[7:4] == ST_PROGRAM) begin
                  push.num              = 2'd1;
                  push.first.event_kind = EV_PROGRAM;
                  push.first.channel    = status_ff[3:0];
                  push.first.data_first = byte_ff;
                  push.first.last       = 1'b1;
                  phase_in              = PH_IDLE;
               end else begin
                  phase_in = PH_SECOND;
               end
            end
            PH_SECOND: begin
               phase_in           = PH_IDLE;
               push.first.channel = status_ff[3:0];
               push.first.last    = 1'b1;
               unique case (status_ff[7:4])
                  ST_NOTE_ON: begin
                     push.num               = 2'd1;
                     push.first.event_kind  = EV_NOTE_ON;
                     push.first.data_first  = first_ff;
                     push.first.data_second = byte_ff;
                  end
                  ST_NOTE_OFF: begin
                     push.num              = 2'd1;
                     push.first.event_kind = EV_NOTE_OFF;
                     push.first.data_first = first_ff;
                  end
                  ST_CC: begin
                     push.num               = 2'd1;
                     push.first.event_kind  = EV_CC;
                     push.first.data_first  = first_ff;
                     push.first.data_second = byte_ff;
                  end
                  ST_BEND: begin
                     push.num              = 2'd1;
                     push.first.event_kind = EV_BEND;
                     push.first.bend_value = {1'b0, byte_ff, 7'd0} +
                                             {{(BEND_W - DATA_W){1'b0}}, first_ff};
                  end
                  default: begin
                     // Song position: both data bytes are consumed silently.
                     push.first = '0;
                  end
               endcase
            end
            PH_SYSEX: begin
               if (byte_ff == SYSEX_END_BYTE) begin
                  push.num                = 2'd1;
                  push.first.event_kind   = EV_SYSEX_END;
                  push.first.sysex_length = LEN_W'(count_ff);
                  push.first.last         = 1'b1;
                  phase_in                = PH_IDLE;
               end else begin
                  count_in              = cnt_inc;
                  push.first.event_kind = EV_SYSEX_BYTE;
                  push.first.data_first = byte_ff;
                  if (cnt_inc >= CNT_W'(SYSEX_MAX)) begin
                     // Byte cap reached: close the message in the same request.
                     push.num                 = 2'd2;
                     push.second.event_kind   = EV_SYSEX_END;
                     push.second.sysex_length = LEN_W'(cnt_inc);
                     push.second.last         = 1'b1;
                     phase_in                 = PH_IDLE;
                  end else begin
                     push.num        = 2'd1;
                     push.first.last = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// File: design/mbsp_rsp_queue.sv
module mbsp_rsp_queue import mbsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   rsp_type           mem_ff [Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  wr_ptr_nxt;
   logic              pop;

   assign out_valid  = fill_ff != '0;
   assign out_data   = mem_ff[rd_ptr_ff];
   assign pop        = out_valid && out_ready;
   assign room       = fill_ff <= FILL_W'(Q_DEPTH - MAX_PUSH);
   assign wr_ptr_nxt = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.num);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(push.num) - FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_ptr_nxt] <= push.second;
      end
   end

endmodule

// File: design/midi_byte_stream_parser_core.sv
// Channel    Role        Payload
// req_chan   sink        rx_byte
// rsp_chan   source      event_kind, channel, data_first, data_second, bend_value,
//                        sysex_length, last
//
// One byte is accepted per cycle while the input register is free or the result queue
// has room. Each byte is registered and then decoded into the result queue; results
// are presented from there one per cycle while the result side is ready.
// A byte that fills the system-exclusive cap yields two results, written into the queue together.
// The input register holds a byte until the four-entry result queue has room for two.
// Reset is synchronous; it returns the parser to idle and empties the queue.
module midi_byte_stream_parser_core import mbsp_pkg::*; #(
   parameter int unsigned SYSEX_MAX = SYSEX_MAX_DEF
) (
   input logic        clock,
   input logic        reset,
   mbsp_req_if.sink   req_chan,
   mbsp_rsp_if.source rsp_chan
);

   push_type push;
   logic     room;
   rsp_type  out_data;

   mbsp_parser #(
      .SYSEX_MAX (SYSEX_MAX)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_byte  (req_chan.rx_byte),
      .in_ready (req_chan.ready),
      .room     (room),
      .push     (push)
   );

   mbsp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.event_kind   = out_data.event_kind;
   assign rsp_chan.channel      = out_data.channel;
   assign rsp_chan.data_first   = out_data.data_first;
   assign rsp_chan.data_second  = out_data.data_second;
   assign rsp_chan.bend_value   = out_data.bend_value;
   assign rsp_chan.sysex_length = out_data.sysex_length;
   assign rsp_chan.last         = out_data.last;

endmodule

// File: design/mbsp_checker.sv
module mbsp_checker import mbsp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [KIND_W-1:0] rsp_event_kind,
   input logic [BEND_W-1:0] rsp_bend_value,
   input logic [LEN_W-1:0]  rsp_sysex_length,
   input logic              rsp_last
);

   // No result may be left over from before a reset.
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind)
                                  && $stable(rsp_sysex_length) && $stable(rsp_last))
      else $error("stalled result changed");

   // A data byte that is not last was the capped one; its end event follows at once.
   a_cap_end_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_event_kind == EV_SYSEX_BYTE && !rsp_last
      |=> rsp_valid && rsp_event_kind == EV_SYSEX_END && rsp_last)
      else $error("capped message end missing");

   a_bend_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_BEND |-> rsp_bend_value == '0)
      else $error("bend value on a non-bend result");

endmodule

bind midi_byte_stream_parser_core mbsp_checker u_mbsp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_event_kind   (rsp_chan.event_kind),
   .rsp_bend_value   (rsp_chan.bend_value),
   .rsp_sysex_length (rsp_chan.sysex_length),
   .rsp_last         (rsp_chan.last)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mbsp_pkg::*;

   localparam int unsigned SYSEX_CAP    = SYSEX_MAX_DEF;
   localparam int unsigned RANDOM_BYTES = 120;
   localparam int unsigned MAX_REPORTS  = 20;

   // Hand-picked opening bytes: every message type, most at their field extremes,
   // real-time bytes, an empty sysex, reset, and bytes the parser drops.
   localparam int unsigned DIRECTED_N = 25;
   localparam logic [7:0] DIRECTED [DIRECTED_N] = '{
      8'h9F, 8'hFF, 8'h00,
      8'h80, 8'h12, 8'h34,
      8'hB5, 8'h00, 8'hFF,
      8'hC7, 8'hFF,
      8'hEA, 8'hFF, 8'hFF,
      8'hF2, 8'h11, 8'h22,
      8'hF8, 8'hFB,
      8'hF0, 8'hF7,
      8'hFF,
      8'h42,
      8'hA3, 8'hF1
   };

   class midi_event_scoreboard;
      phase_type         phase = PH_IDLE;
      logic [7:0]        status = '0;
      logic [7:0]        first_data = '0;
      int unsigned       sysex_count = 0;
      rsp_type           expected_events[$];
      int unsigned       errors = 0;
      int unsigned       bytes_taken = 0;
      int unsigned       events_checked = 0;
      int unsigned       caps_hit = 0;
      int unsigned       kind_seen[8];

      function int unsigned pending();
         return expected_events.size();
      endfunction

      function rsp_type event_of(event_kind_type kind, logic [CHAN_W-1:0] chan,
                                 logic [DATA_W-1:0] d1, logic [DATA_W-1:0] d2,
                                 logic [BEND_W-1:0] bend, logic [LEN_W-1:0] len);
         rsp_type ev;
         ev.event_kind   = kind;
         ev.channel      = chan;
         ev.data_first   = d1;
         ev.data_second  = d2;
         ev.bend_value   = bend;
         ev.sysex_length = len;
         ev.last         = 1'b0;
         return ev;
      endfunction

      // Advances the parser state by one accepted request byte and queues the
      // events it produces.
      function void take_byte(logic [DATA_W-1:0] b);
         rsp_type           made[$];
         logic [3:0]        st_hi;
         logic [3:0]        st_lo;
         logic [BEND_W-1:0] bend;
         st_hi = status[7:4];
         st_lo = status[3:0];
         bytes_taken++;
         case (phase)
            PH_IDLE: begin
               status = b;
               if (b[7:4] inside {ST_NOTE_ON, ST_NOTE_OFF, ST_CC, ST_BEND, ST_PROGRAM}) begin
                  phase = PH_FIRST;
               end else if (b[7:4] == ST_SYSTEM) begin
                  if (b[3:0] == SYS_SONG_POS) begin
                     phase = PH_FIRST;
                  end else if (b[3:0] == SYS_SYSEX_START) begin
                     sysex_count = 0;
                     phase = PH_SYSEX;
                  end else if (b[3:0] == SYS_RESET) begin
                     made.push_back(event_of(EV_RESET, '0, '0, '0, '0, '0));
                  end
               end
            end
            PH_FIRST: begin
               first_data = b;
               if (st_hi == ST_PROGRAM) begin
                  made.push_back(event_of(EV_PROGRAM, st_lo, b, '0, '0, '0));
                  phase = PH_IDLE;
               end else begin
                  phase = PH_SECOND;
               end
            end
            PH_SECOND: begin
               case (st_hi)
                  ST_NOTE_ON:  made.push_back(event_of(EV_NOTE_ON, st_lo, first_data, b,
                                                       '0, '0));
                  ST_NOTE_OFF: made.push_back(event_of(EV_NOTE_OFF, st_lo, first_data, '0,
                                                       '0, '0));
                  ST_CC:       made.push_back(event_of(EV_CC, st_lo, first_data, b, '0, '0));
                  ST_BEND: begin
                     bend = {1'b0, b, 7'b0} + {8'b0, first_data};
                     made.push_back(event_of(EV_BEND, st_lo, '0, '0, bend, '0));
                  end
                  default: ;
               endcase
               phase = PH_IDLE;
            end
            default: begin
               if (b == SYSEX_END_BYTE) begin
                  made.push_back(event_of(EV_SYSEX_END, '0, '0, '0, '0, LEN_W'(sysex_count)));
                  phase = PH_IDLE;
               end else begin
                  made.push_back(event_of(EV_SYSEX_BYTE, '0, b, '0, '0, '0));
                  sysex_count++;
                  if (sysex_count >= SYSEX_CAP) begin
                     made.push_back(event_of(EV_SYSEX_END, '0, '0, '0, '0,
                                             LEN_W'(sysex_count)));
                     phase = PH_IDLE;
                     caps_hit++;
                  end
               end
            end
         endcase
         if (made.size() > 0) made[made.size() - 1].last = 1'b1;
         foreach (made[i]) expected_events.push_back(made[i]);
      endfunction

      task report_mismatch(string what);
         if (errors < MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, what);
         errors++;
      endtask

      task compare_field(string field, logic [15:0] got_v, logic [15:0] want_v);
         if (got_v !== want_v)
            report_mismatch($sformatf("event %0d %s is %0h, expected %0h",
                                      events_checked, field, got_v, want_v));
      endtask

      task check_event(rsp_type got);
         rsp_type oldest;
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("event of kind %0d arrived with none outstanding",
                                      got.event_kind));
            return;
         end
         oldest = expected_events.pop_front();
         compare_field("event_kind", 16'(got.event_kind), 16'(oldest.event_kind));
         compare_field("channel", 16'(got.channel), 16'(oldest.channel));
         compare_field("data_first", 16'(got.data_first), 16'(oldest.data_first));
         compare_field("data_second", 16'(got.data_second), 16'(oldest.data_second));
         compare_field("bend_value", got.bend_value, oldest.bend_value);
         compare_field("sysex_length", 16'(got.sysex_length), 16'(oldest.sysex_length));
         compare_field("last", 16'(got.last), 16'(oldest.last));
         kind_seen[oldest.event_kind]++;
         events_checked++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   int          burst_left;
   int unsigned rx_cycle = 0;

   mbsp_req_if req_chan ();
   mbsp_rsp_if rsp_chan ();

   midi_event_scoreboard sb = new;

   midi_byte_stream_parser_core #(.SYSEX_MAX(SYSEX_CAP)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Result side: check on every handshake, and cycle through stall modes of
   // always ready, mostly ready, mostly stalled, and long stalls.
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.event_kind   = rsp_chan.event_kind;
         got.channel      = rsp_chan.channel;
         got.data_first   = rsp_chan.data_first;
         got.data_second  = rsp_chan.data_second;
         got.bend_value   = rsp_chan.bend_value;
         got.sysex_length = rsp_chan.sysex_length;
         got.last         = rsp_chan.last;
         sb.check_event(got);
      end
      rx_cycle++;
      case ((rx_cycle / 40) % 4)
         0:       rsp_chan.ready <= 1'b1;
         1:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_chan.ready <= ((rx_cycle % 16) >= 12);
      endcase
   end

   // Presents one byte and returns at the edge where the request is taken.
   // Bursts end with a random gap; some bursts run back to back.
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      sb.take_byte(b);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 15) == 0) gap = 20;
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
   endtask

   // Holds off the sender until every outstanding event has been checked.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [7:0] data_byte();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(128, 255));
      return 8'($urandom_range(0, 127));
   endfunction

   // A system-exclusive block long enough to reach the cap; the trailing end
   // byte then arrives while idle and is dropped.
   task automatic send_capped_sysex();
      logic [7:0] b;
      send_byte({ST_SYSTEM, SYS_SYSEX_START});
      repeat (SYSEX_CAP) begin
         b = 8'($urandom_range(0, 255));
         if (b == SYSEX_END_BYTE) b = 8'h77;
         send_byte(b);
      end
      send_byte(SYSEX_END_BYTE);
   endtask

   // One random message; counted is the number of bytes the parser acts on.
   task automatic send_random_message(output int unsigned counted);
      int unsigned pick;
      int unsigned len;
      logic [3:0]  chan;
      pick = $urandom_range(0, 99);
      chan = 4'($urandom_range(0, 15));
      counted = 0;
      if (pick < 18) begin
         send_byte({ST_NOTE_ON, chan}); send_byte(data_byte()); send_byte(data_byte());
         counted = 3;
      end else if (pick < 28) begin
         send_byte({ST_NOTE_OFF, chan}); send_byte(data_byte()); send_byte(data_byte());
         counted = 3;
      end else if (pick < 40) begin
         send_byte({ST_CC, chan}); send_byte(data_byte()); send_byte(data_byte());
         counted = 3;
      end else if (pick < 50) begin
         send_byte({ST_PROGRAM, chan}); send_byte(data_byte());
         counted = 2;
      end else if (pick < 60) begin
         send_byte({ST_BEND, chan}); send_byte(data_byte()); send_byte(data_byte());
         counted = 3;
      end else if (pick < 65) begin
         send_byte({ST_SYSTEM, SYS_SONG_POS}); send_byte(data_byte());
         send_byte(data_byte());
         counted = 3;
      end else if (pick < 75) begin
         // A data byte that happens to be the end byte closes the block early
         // and the rest is parsed as a stray sequence.
         len = $urandom_range(0, 12);
         send_byte({ST_SYSTEM, SYS_SYSEX_START});
         repeat (len) send_byte(8'($urandom_range(0, 255)));
         send_byte(SYSEX_END_BYTE);
         counted = len + 2;
      end else if (pick < 78) begin
         send_byte({ST_SYSTEM, SYS_RESET});
         counted = 1;
      end else if (pick < 85) begin
         case ($urandom_range(0, 3))
            0:       send_byte(8'hF8);
            1:       send_byte(8'hFA);
            2:       send_byte(8'hFB);
            default: send_byte(8'hFC);
         endcase
      end else if (pick < 92) begin
         send_byte(8'($urandom_range(0, 255)));
      end else begin
         // Often truncated: the next status byte may be swallowed as data.
         send_byte({4'($urandom_range(8, 15)), chan});
         send_byte(data_byte());
         counted = 2;
      end
   endtask

   initial begin
      int unsigned sent;
      int unsigned counted;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      burst_left       = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
      wait_for_drain();
      send_capped_sysex();

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         send_random_message(counted);
         sent += counted;
         if ($urandom_range(0, 29) == 0) wait_for_drain();
      end

      wait_for_drain();
      repeat (20) @(posedge clock);

      $display("Run covered %0d request bytes and %0d events, %0d sysex cap(s) reached.",
               sb.bytes_taken, sb.events_checked, sb.caps_hit);
      $display("Events by kind: on %0d off %0d cc %0d bend %0d prog %0d sx %0d sxend %0d rst %0d",
               sb.kind_seen[EV_NOTE_ON], sb.kind_seen[EV_NOTE_OFF], sb.kind_seen[EV_CC],
               sb.kind_seen[EV_BEND], sb.kind_seen[EV_PROGRAM], sb.kind_seen[EV_SYSEX_BYTE],
               sb.kind_seen[EV_SYSEX_END], sb.kind_seen[EV_RESET]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
